[src/pbcc_pkg.sv]
// Package: types, constants and helpers for the pulse battery charge controller
package pbcc_pkg;

  localparam int unsigned BATTERY_COUNT = 3;
  localparam int unsigned NBAT          = 3;
  localparam int unsigned DUTY_FLOOR    = 256;
  localparam int unsigned FULL_DUTY     = 25600;
  localparam int          NIGHT_PANEL   = 2560;
  localparam int unsigned BAT_W         = 2;

  typedef enum logic [1:0] {
    PH_REST   = 2'd0,
    PH_BULK   = 2'd1,
    PH_ABSORB = 2'd2,
    PH_FLOAT  = 2'd3
  } phase_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ALPHA_V   = 3'd0,
    REG_ALPHA_I   = 3'd1,
    REG_ABS_V     = 3'd2,
    REG_FLOAT_I   = 3'd3,
    REG_BULK_I    = 3'd4,
    REG_MIN_REST  = 3'd5,
    REG_FLOAT_DLY = 3'd6,
    REG_ABS_TICKS = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] bat0_voltage;
    logic signed [15:0] bat0_current;
    logic signed [15:0] bat1_voltage;
    logic signed [15:0] bat1_current;
    logic signed [15:0] bat2_voltage;
    logic signed [15:0] bat2_current;
    logic signed [15:0] temperature;
    logic signed [15:0] panel_voltage;
    logic [1:0]         selected_battery;
  } in_word_t;

  typedef struct packed {
    logic        duty_valid;
    logic [14:0] duty_cycle;
    logic [1:0]  phase_bat0;
    logic [1:0]  phase_bat1;
    logic [1:0]  phase_bat2;
    logic        soc_reset;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  alpha_v;
    logic [7:0]  alpha_i;
    logic [14:0] abs_v;
    logic [14:0] float_i;
    logic [14:0] bulk_i;
    logic [31:0] min_rest;
    logic [31:0] float_dly;
    logic [31:0] abs_ticks;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILTER,
    ST_LIMIT,
    ST_PHASE,
    ST_PEAK_START,
    ST_PEAK_WAIT,
    ST_DMAX_START,
    ST_DMAX_WAIT,
    ST_FINISH,
    ST_OUT
  } ctl_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic filter;
    logic limit;
    logic phase;
    logic peak_start;
    logic dmax_start;
    logic finish;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_done;
    logic sel_ok;
  } dp_sts_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    logic [31:0] r;
    r = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    return r;
  endfunction

endpackage

[src/pbcc_div.sv]
// Radix-2 restoring divider for unsigned 32-bit operands, one quotient bit per cycle
module pbcc_div import pbcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  // one shift-subtract step a cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[31]} - {1'b0, dsr_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[src/pbcc_datapath.sv]
// Datapath: per-battery state, filters, phase logic and duty regulation
module pbcc_datapath import pbcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_word_t  in_word,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_word_t out_word
);

  // per-battery state
  phase_t             phase_r    [NBAT];
  logic signed [15:0] vavg_r     [NBAT];
  logic signed [15:0] iavg_r     [NBAT];
  logic [31:0]        rest_r     [NBAT];
  logic [31:0]        abst_r     [NBAT];
  logic signed [15:0] absi_r     [NBAT];
  logic [14:0]        duty_r     [NBAT];

  in_word_t           in_r;
  logic signed [17:0] lim_r;
  logic               soc_r;
  logic [31:0]        peak_r;
  logic               peak_neg_r;
  logic               cap_r;
  logic [31:0]        dmax_r;
  out_word_t          out_r;

  logic signed [15:0] vin [NBAT];
  logic signed [15:0] iin [NBAT];
  logic [1:0]         b;
  logic               sel_ok;
  logic               night;

  assign vin[0] = in_r.bat0_voltage;
  assign iin[0] = in_r.bat0_current;
  assign vin[1] = in_r.bat1_voltage;
  assign iin[1] = in_r.bat1_current;
  assign vin[2] = in_r.bat2_voltage;
  assign iin[2] = in_r.bat2_current;

  assign sel_ok = (in_r.selected_battery != 2'd0) &&
                  ({30'd0, in_r.selected_battery} <= BATTERY_COUNT);
  assign b      = in_r.selected_battery - 2'd1;
  assign night  = in_r.panel_voltage < 16'sd2560;

  // IIR step: avg + floor(alpha*(x-avg)/256), seeded from x when avg is zero
  function automatic logic signed [15:0] iir(input logic signed [15:0] avg,
                                             input logic signed [15:0] x,
                                             input logic [7:0] alpha);
    logic signed [15:0] a;
    logic signed [17:0] diff;
    logic signed [26:0] prod;
    logic signed [26:0] sum;
    a    = (avg == 16'sd0) ? x : avg;
    diff = 18'(x) - 18'(a);
    prod = diff * $signed({1'b0, alpha});
    sum  = 27'(a) + (prod >>> 8);
    return sum[15:0];
  endfunction

  // divider shared by the peak and cap computations
  logic        div_start;
  logic [31:0] div_a, div_b, div_q;
  logic        div_done;

  pbcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // peak = -(cur*100)/duty, truncating; magnitude divided, a negative result or zero duty gives 0
  logic signed [23:0] negcur;
  logic [23:0]        negcur_mag;
  always_comb begin
    negcur     = -(24'(iin[b]) * 24'sd100);
    negcur_mag = negcur[23] ? -negcur : negcur;
    div_start  = cmd.peak_start | cmd.dmax_start;
    if (cmd.dmax_start) begin
      div_a = {9'd0, cfg.bulk_i, 8'd0};
      div_b = peak_r;
    end else begin
      div_a = {8'd0, negcur_mag};
      div_b = {17'd0, duty_r[b]};
    end
  end

  // phase update combinational helpers
  logic        any_bulk;
  logic        bulk_other;
  always_comb begin
    any_bulk   = 1'b0;
    bulk_other = 1'b0;
    for (int i = 0; i < BATTERY_COUNT; i++) begin
      if (phase_r[i] == PH_BULK) any_bulk = 1'b1;
      if (phase_r[i] == PH_BULK && 2'(i) != b) bulk_other = 1'b1;
    end
  end

  // scaled limits, truncating toward zero
  function automatic logic signed [17:0] scale_lim(input logic signed [17:0] l,
                                                   input logic [8:0] k);
    logic signed [27:0] p;
    logic signed [27:0] q;
    p = l * $signed({1'b0, k});
    q = p[27] ? -((-p) >>> 8) : (p >>> 8);
    return q[17:0];
  endfunction

  logic signed [17:0] lim_nxt;
  logic signed [17:0] lim_245, lim_268;
  logic signed [27:0] gas_prod;
  logic signed [27:0] gas_shift;
  always_comb begin
    gas_prod  = 28'sd1984 * (28'sd6835 - 28'(in_r.temperature));
    gas_shift = gas_prod >>> 16;
    lim_nxt   = 18'($signed({1'b0, cfg.abs_v})) + gas_shift[17:0];
    lim_245   = scale_lim(lim_r, 9'd245);
    lim_268   = scale_lim(lim_r, 9'd268);
  end

  // absorption current threshold 240*ac/256 truncating
  logic signed [25:0] ac240;
  logic signed [17:0] ac_thr;
  logic [21:0]        dmul;
  logic [14:0]        dreg;
  always_comb begin
    ac240  = absi_r[b] * 26'sd240;
    ac_thr = ac240[25] ? 18'(-((-ac240) >>> 8)) : 18'(ac240 >>> 8);
    if (vavg_r[b] > lim_r) begin
      if (18'(vavg_r[b]) > lim_268) dmul = 22'(duty_r[b]) * 22'd90;
      else dmul = 22'(duty_r[b]) * 22'd115;
    end else begin
      dmul = 22'(duty_r[b]) * 22'd140;
    end
    dreg = dmul[21:7];
  end

  // final duty after cap and floor; without the cap full duty is the ceiling
  logic [14:0] dcap;
  always_comb begin
    dcap = duty_r[b];
    if (cap_r) begin
      if ({17'd0, dcap} > dmax_r) dcap = dmax_r[14:0];
    end else if (dcap > 15'(FULL_DUTY)) begin
      dcap = 15'(FULL_DUTY);
    end
    if (dcap < 15'(DUTY_FLOOR)) dcap = 15'(DUTY_FLOOR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NBAT; i++) begin
        phase_r[i] <= PH_BULK;
        vavg_r[i]  <= '0;
        iavg_r[i]  <= '0;
        rest_r[i]  <= '0;
        abst_r[i]  <= '0;
        absi_r[i]  <= '0;
        duty_r[i]  <= 15'(FULL_DUTY);
      end
      soc_r <= 1'b0;
      cap_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        in_r  <= in_word;
        soc_r <= 1'b0;
        cap_r <= 1'b0;
      end
      // filters, rest timers and night handling
      if (cmd.filter) begin
        for (int i = 0; i < BATTERY_COUNT; i++) begin
          vavg_r[i] <= iir(vavg_r[i], vin[i], cfg.alpha_v);
          iavg_r[i] <= iir(iavg_r[i], iin[i], cfg.alpha_i);
          if (phase_r[i] == PH_REST) begin
            // rest timer runs first, night then clears it
            rest_r[i] <= night ? '0 : sat_inc(rest_r[i]);
            if (sat_inc(rest_r[i]) > cfg.min_rest) phase_r[i] <= PH_BULK;
          end else if (night) begin
            rest_r[i] <= '0;
            if (phase_r[i] == PH_ABSORB) phase_r[i] <= PH_REST;
          end
        end
      end
      if (cmd.limit) lim_r <= lim_nxt;
      // selected battery's phase step
      if (cmd.phase && sel_ok) begin
        if (phase_r[b] == PH_BULK) begin
          abst_r[b] <= '0;
          absi_r[b] <= iavg_r[b];
          // absorption starts at half duty
          if ((18'(vavg_r[b]) > lim_r) && !bulk_other) duty_r[b] <= 15'(FULL_DUTY / 2);
          else duty_r[b] <= 15'(FULL_DUTY);
          if (18'(vavg_r[b]) > lim_r) begin
            rest_r[b] <= '0;
            // another battery still in bulk sends this one to rest
            phase_r[b] <= bulk_other ? PH_REST : PH_ABSORB;
          end
        end else if (phase_r[b] == PH_ABSORB) begin
          logic [31:0] at;
          phase_t      ph;
          logic signed [15:0] ac;
          at = abst_r[b];
          ph = PH_ABSORB;
          ac = absi_r[b];
          rest_r[b] <= '0;
          if (at > cfg.abs_ticks && any_bulk) begin
            ph = PH_REST;
            at = '0;
          end
          if (ac_thr > 18'(iavg_r[b])) begin
            at = sat_inc(at);
            if (at > cfg.float_dly) begin
              ph = PH_FLOAT;
              at = '0;
              ac = '0;
            end
          end else begin
            ac = '0;
          end
          if ((-18'(iavg_r[b]) < 18'($signed({1'b0, cfg.float_i}))) &&
              (18'(vavg_r[b]) > lim_245)) begin
            ph = PH_FLOAT;
            at = '0;
            soc_r <= 1'b1;
          end
          phase_r[b] <= ph;
          abst_r[b]  <= at;
          absi_r[b]  <= ac;
          duty_r[b]  <= dreg;
        end
      end
      // overcurrent cap decision from the peak
      if (cmd.dmax_start) begin
        cap_r <= ~peak_neg_r && (peak_r > {17'd0, cfg.bulk_i});
      end
      if (cmd.finish && sel_ok) duty_r[b] <= dcap;
    end
  end

  // quotient capture
  always_ff @(posedge clk) begin
    if (cmd.peak_start) peak_neg_r <= negcur[23];
    if (div_done && !cmd.dmax_start) begin
      if (cap_r) dmax_r <= div_q;
      else if (duty_r[b] == 15'd0) peak_r <= '0;
      else peak_r <= peak_neg_r ? '0 : div_q;
    end
  end

  // result word, registered
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.duty_valid <= sel_ok;
      out_r.duty_cycle <= (sel_ok && !night && phase_r[b] != PH_REST &&
                           phase_r[b] != PH_FLOAT) ? dcap : 15'd0;
      out_r.phase_bat0 <= phase_r[0];
      out_r.phase_bat1 <= phase_r[1];
      out_r.phase_bat2 <= phase_r[2];
      out_r.soc_reset  <= sel_ok & soc_r;
    end
  end

  assign sts.div_done = div_done;
  assign sts.sel_ok   = sel_ok;
  assign out_word     = out_r;

endmodule

[src/pbcc_ctrl.sv]
// Controller: sequences one word through the datapath
module pbcc_ctrl import pbcc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt     = state_r;
    case (state_r)
      ST_IDLE:       if (in_valid) state_nxt = ST_FILTER;
      ST_FILTER:     state_nxt = ST_LIMIT;
      ST_LIMIT:      state_nxt = ST_PHASE;
      ST_PHASE:      state_nxt = sts.sel_ok ? ST_PEAK_START : ST_FINISH;
      ST_PEAK_START: state_nxt = ST_PEAK_WAIT;
      ST_PEAK_WAIT:  if (sts.div_done) state_nxt = ST_DMAX_START;
      ST_DMAX_START: state_nxt = ST_DMAX_WAIT;
      ST_DMAX_WAIT:  if (sts.div_done) state_nxt = ST_FINISH;
      ST_FINISH:     state_nxt = ST_OUT;
      ST_OUT:        if (out_ready) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_FILTER:     cmd.filter     = 1'b1;
      ST_LIMIT:      cmd.limit      = 1'b1;
      ST_PHASE:      cmd.phase      = 1'b1;
      ST_PEAK_START: cmd.peak_start = 1'b1;
      ST_DMAX_START: cmd.dmax_start = 1'b1;
      ST_FINISH:     cmd.finish     = 1'b1;
      ST_OUT:        out_valid      = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
    end else begin
      state_r     <= state_nxt;
    end
  end

  // assertions
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output overlap");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

[src/pulse_battery_charge_controller.sv]
// Top level: pulse battery charge controller with APB register port
//
// channel | ports                          | dir
// input   | in_valid in_ready in_data      | in
// result  | out_valid out_ready out_data   | out
// config  | cfg_psel ... cfg_prdata        | in/out
//
// A selected battery word waits twice on the shared restoring divider
// (peak current, then overcurrent cap) before its result is ready; an
// unselected battery word skips both waits. One word is in work at a time.
// Synchronous active-low reset sets the controller, per-battery state and
// configuration; the input word, limit, peak, divider data and result
// registers are not reset. A held result stalls input until it is taken.
module pulse_battery_charge_controller import pbcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_sts_t  sts;
  reg_idx_t widx;

  assign cfg_pready = 1'b1;
  assign widx       = reg_idx_t'(cfg_paddr[4:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha_v   <= 8'd64;
      cfg_r.alpha_i   <= 8'd64;
      cfg_r.abs_v     <= 15'd3686;
      cfg_r.float_i   <= 15'd128;
      cfg_r.bulk_i    <= 15'd2560;
      cfg_r.min_rest  <= 32'd1000;
      cfg_r.float_dly <= 32'd1000;
      cfg_r.abs_ticks <= 32'd500;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (widx)
        REG_ALPHA_V:   cfg_r.alpha_v   <= cfg_pwdata[7:0];
        REG_ALPHA_I:   cfg_r.alpha_i   <= cfg_pwdata[7:0];
        REG_ABS_V:     cfg_r.abs_v     <= cfg_pwdata[14:0];
        REG_FLOAT_I:   cfg_r.float_i   <= cfg_pwdata[14:0];
        REG_BULK_I:    cfg_r.bulk_i    <= cfg_pwdata[14:0];
        REG_MIN_REST:  cfg_r.min_rest  <= cfg_pwdata;
        REG_FLOAT_DLY: cfg_r.float_dly <= cfg_pwdata;
        REG_ABS_TICKS: cfg_r.abs_ticks <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (widx)
      REG_ALPHA_V:   cfg_prdata = {24'd0, cfg_r.alpha_v};
      REG_ALPHA_I:   cfg_prdata = {24'd0, cfg_r.alpha_i};
      REG_ABS_V:     cfg_prdata = {17'd0, cfg_r.abs_v};
      REG_FLOAT_I:   cfg_prdata = {17'd0, cfg_r.float_i};
      REG_BULK_I:    cfg_prdata = {17'd0, cfg_r.bulk_i};
      REG_MIN_REST:  cfg_prdata = cfg_r.min_rest;
      REG_FLOAT_DLY: cfg_prdata = cfg_r.float_dly;
      REG_ABS_TICKS: cfg_prdata = cfg_r.abs_ticks;
      default:       cfg_prdata = '0;
    endcase
  end

  pbcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pbcc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_word  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_data)
  );

endmodule
